[sv/ipc_pkg.sv]
package ipc_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int POS_W     = 10;
   localparam int COUNT_W   = 20;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [0:0] KIND_POSITION = 1'b0;
   localparam logic [0:0] KIND_TOTAL    = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
   localparam logic [8:0]         CENTER_ONLY = 9'h010;
   localparam logic [CFG_W-1:0]   RESET_SIZE  = 11'd12;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic               has_pos;
      logic               has_total;
      logic [POS_W-1:0]   row;
      logic [POS_W-1:0]   col;
      logic [COUNT_W-1:0] total;
   } ipc_event_type;

endpackage

[sv/ipc_if.sv]
interface ipc_req_if;
   logic valid;
   logic ready;
   logic pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface ipc_rsp_if;
   logic       valid;
   logic       ready;
   logic       report_kind;
   logic [9:0] pixel_row;
   logic [9:0] pixel_col;
   logic [19:0] isolated_total;
   logic       last_of_run;

   modport source (output valid, output report_kind, output pixel_row, output pixel_col,
                   output isolated_total, output last_of_run, input ready);
   modport sink (input valid, input report_kind, input pixel_row, input pixel_col,
                 input isolated_total, input last_of_run, output ready);
endinterface

[sv/ipc_front.sv]
module ipc_front
   import ipc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 pix_valid,
   input  logic                 pixel,
   output logic                 pix_ready,
   input  logic [Q_CW-1:0]      q_count,
   output logic                 ev_push,
   output ipc_event_type        ev_data
);

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int RLW = $clog2(MAX_HEIGHT);
   localparam int SZW_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int SZW_H = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

   logic [CFG_W-1:0]   width_ff, height_ff;
   logic [CLW-1:0]     col_ff, col_in;
   logic [RLW-1:0]     row_ff, row_in;
   logic               s1_valid_ff;
   logic               s1_pixel_ff;
   logic [CLW-1:0]     s1_col_ff;
   logic [RLW-1:0]     s1_row_ff;
   logic               s1_end_frame_ff;
   logic [8:0]         window_ff, window_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         line_mem [MAX_WIDTH];
   logic [1:0]         line_rd_ff;

   logic [SZW_W-1:0]   w_ext, w_eff;
   logic [SZW_H-1:0]   h_ext, h_eff;
   logic               accept, end_row, end_frame, hit;
   logic [COUNT_W-1:0] count_hit;
   logic [Q_CW:0]      occupancy;

   assign occupancy = {1'b0, q_count} + (Q_CW + 1)'(s1_valid_ff);
   assign pix_ready = (occupancy < (Q_CW + 1)'(Q_DEPTH));
   assign accept    = pix_valid && pix_ready;

   always_comb begin
      w_ext = SZW_W'(width_ff);
      h_ext = SZW_H'(height_ff);
      if (w_ext < SZW_W'(3)) w_eff = SZW_W'(3);
      else if (w_ext > SZW_W'(MAX_WIDTH)) w_eff = SZW_W'(MAX_WIDTH);
      else w_eff = w_ext;
      if (h_ext < SZW_H'(3)) h_eff = SZW_H'(3);
      else if (h_ext > SZW_H'(MAX_HEIGHT)) h_eff = SZW_H'(MAX_HEIGHT);
      else h_eff = h_ext;
      end_row   = (SZW_W'(col_ff) + SZW_W'(1)) >= w_eff;
      end_frame = end_row && ((SZW_H'(row_ff) + SZW_H'(1)) >= h_eff);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (end_frame) begin
            col_in = '0;
            row_in = '0;
         end else if (end_row) begin
            col_in = '0;
            row_in = row_ff + RLW'(1);
         end else begin
            col_in = col_ff + CLW'(1);
         end
      end
   end

   always_comb begin
      window_in = {s1_pixel_ff, line_rd_ff[1], line_rd_ff[0], window_ff[8:3]};
      hit = s1_valid_ff && (s1_row_ff >= RLW'(2)) && (s1_col_ff >= CLW'(2))
            && (window_in == CENTER_ONLY);
      count_hit = (hit && (count_ff != COUNT_MAX)) ? count_ff + COUNT_W'(1) : count_ff;
      count_in = count_ff;
      if (s1_valid_ff) count_in = s1_end_frame_ff ? '0 : count_hit;
      ev_push = s1_valid_ff && (hit || s1_end_frame_ff);
      ev_data.has_pos   = hit;
      ev_data.has_total = s1_end_frame_ff;
      ev_data.row       = POS_W'(s1_row_ff - RLW'(1));
      ev_data.col       = POS_W'(s1_col_ff - CLW'(1));
      ev_data.total     = count_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RESET_SIZE;
         height_ff   <= RESET_SIZE;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         window_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FRAME_WIDTH:  width_ff <= csr_wdata;
               REG_FRAME_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         if (s1_valid_ff) window_ff <= window_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff     <= pixel;
         s1_col_ff       <= col_ff;
         s1_row_ff       <= row_ff;
         s1_end_frame_ff <= end_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) line_rd_ff <= line_mem[col_ff];
      if (s1_valid_ff) line_mem[s1_col_ff] <= {s1_pixel_ff, line_rd_ff[1]};
   end

endmodule

[sv/ipc_queue.sv]
module ipc_queue
   import ipc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ipc_event_type push_data,
   input  logic          pop,
   output logic          not_empty,
   output ipc_event_type head,
   output logic [Q_CW-1:0] count
);

   ipc_event_type     slots_ff [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CW-1:0]   count_ff;

   assign not_empty = (count_ff != '0);
   assign head      = slots_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_AW'(1);
         if (pop) rd_ptr_ff <= (rd_ptr_ff == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_AW'(1);
         case ({push, pop})
            2'b10:   count_ff <= count_ff + Q_CW'(1);
            2'b01:   count_ff <= count_ff - Q_CW'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[sv/ipc_back.sv]
module ipc_back
   import ipc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          ev_ready,
   input  ipc_event_type ev_head,
   output logic          ev_pop,
   ipc_rsp_if.source     rsp_ch
);

   logic               valid_ff, valid_in;
   logic               phase_ff, phase_in;
   logic               kind_ff, kind_in;
   logic [POS_W-1:0]   row_ff, row_in;
   logic [POS_W-1:0]   col_ff, col_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               last_ff, last_in;
   logic               out_free, load;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign load     = out_free && ev_ready;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      kind_in  = kind_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      total_in = total_ff;
      last_in  = last_ff;
      ev_pop   = 1'b0;
      if (out_free) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         total_in = ev_head.total;
         if (ev_head.has_pos && !phase_ff) begin
            kind_in = KIND_POSITION;
            row_in  = ev_head.row;
            col_in  = ev_head.col;
            last_in = !ev_head.has_total;
            if (ev_head.has_total) phase_in = 1'b1;
            else ev_pop = 1'b1;
         end else begin
            kind_in  = KIND_TOTAL;
            row_in   = '0;
            col_in   = '0;
            last_in  = 1'b1;
            phase_in = 1'b0;
            ev_pop   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      total_ff <= total_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.report_kind    = kind_ff;
   assign rsp_ch.pixel_row      = row_ff;
   assign rsp_ch.pixel_col      = col_ff;
   assign rsp_ch.isolated_total = total_ff;
   assign rsp_ch.last_of_run    = last_ff;

endmodule

[sv/isolated_pixel_counter.sv]
// Isolated pixel counter, 8-neighbour.
// req_ch takes one binary pixel per item in raster order. rsp_ch gives a
// position item for each interior pixel that is 1 with all eight neighbours
// 0 (row, column, running count), and after the last pixel of a frame a
// total item; last_of_run marks the final item caused by one pixel.
// csr_we/csr_index/csr_wdata set frame_width (index 0) and frame_height
// (index 1); write them only while the block is idle.
// Throughput: one pixel per cycle. A pixel whose judgment gives both a
// position and a total yields two output items; the four-entry event queue
// absorbs that, so sustained input stalls only when such pixels follow
// each other or the receiver stalls.
// After acceptance a pixel's items pass the line store read, the window
// judge, the event queue and the output register, plus any queue wait.
// Reset clears position, window, count, queue and output; the line stores
// are not cleared; their contents are used only once written in the frame.
// When rsp_ch.ready is low the output holds, the queue fills and then
// req_ch.ready drops; no item is lost.
module isolated_pixel_counter
   import ipc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   ipc_req_if.sink              req_ch,
   ipc_rsp_if.source            rsp_ch
);

   logic            ev_push, ev_pop, ev_ready, pix_ready;
   ipc_event_type   ev_data, ev_head;
   logic [Q_CW-1:0] q_count;

   assign req_ch.ready = pix_ready;

   ipc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pix_valid (req_ch.valid),
      .pixel     (req_ch.pixel),
      .pix_ready (pix_ready),
      .q_count   (q_count),
      .ev_push   (ev_push),
      .ev_data   (ev_data)
   );

   ipc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_data),
      .pop       (ev_pop),
      .not_empty (ev_ready),
      .head      (ev_head),
      .count     (q_count)
   );

   ipc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .ev_ready (ev_ready),
      .ev_head  (ev_head),
      .ev_pop   (ev_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
